// ----- rtl/core/psht_pkg.sv -----
// shared types and constants of the polyline stroke hit test
`default_nettype none
package psht_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned NORM_W  = 18;
  localparam int unsigned TOL_W   = 31;
  localparam int unsigned DIST_W  = 32;
  localparam int unsigned IDX_W   = 4;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_QUERY_X   = 4'd0,
    REG_QUERY_Y   = 4'd1,
    REG_TOLERANCE = 4'd2,
    REG_OUTLINE   = 4'd3,
    REG_BOX_MIN_X = 4'd4,
    REG_BOX_MIN_Y = 4'd5,
    REG_BOX_MAX_X = 4'd6,
    REG_BOX_MAX_Y = 4'd7
  } reg_idx_e;

  // one centerline sample, normals sign-extended to full width
  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] ly;
  } smp_t;

  // product sequence of the shared multiplier
  typedef enum logic [3:0] {
    OP_DXX  = 4'd0,
    OP_DYY  = 4'd1,
    OP_SXX  = 4'd2,
    OP_SYY  = 4'd3,
    OP_PXSX = 4'd4,
    OP_PYSY = 4'd5,
    OP_PXSY = 4'd6,
    OP_PYSX = 4'd7,
    OP_C0A  = 4'd8,
    OP_C0B  = 4'd9,
    OP_C1A  = 4'd10,
    OP_C1B  = 4'd11,
    OP_C2A  = 4'd12,
    OP_C2B  = 4'd13,
    OP_C3A  = 4'd14,
    OP_C3B  = 4'd15
  } op_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_PSQ  = 6'b000100,
    ST_SSQ  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

endpackage
`default_nettype wire

// ----- rtl/core/psht_if.sv -----
// item channels of the polyline stroke hit test
`default_nettype none
interface psht_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [psht_pkg::IDX_W-1:0]          index;
  logic [psht_pkg::COORD_W-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface psht_smp_if;
  logic                                valid;
  logic                                ready;
  logic signed [psht_pkg::COORD_W-1:0] sample_x;
  logic signed [psht_pkg::COORD_W-1:0] sample_y;
  logic signed [psht_pkg::NORM_W-1:0]  normal_x;
  logic signed [psht_pkg::NORM_W-1:0]  normal_y;
  logic signed [psht_pkg::COORD_W-1:0] right_x;
  logic signed [psht_pkg::COORD_W-1:0] right_y;
  logic signed [psht_pkg::COORD_W-1:0] left_x;
  logic signed [psht_pkg::COORD_W-1:0] left_y;
  logic                                last_sample;
  modport source (output valid, sample_x, sample_y, normal_x, normal_y, right_x, right_y,
                  left_x, left_y, last_sample, input ready);
  modport sink (input valid, sample_x, sample_y, normal_x, normal_y, right_x, right_y,
                left_x, left_y, last_sample, output ready);
endinterface

interface psht_res_if;
  logic                                valid;
  logic                                ready;
  logic                                selected;
  logic [psht_pkg::DIST_W-1:0]         hit_distance;
  modport source (output valid, selected, hit_distance, input ready);
  modport sink (input valid, selected, hit_distance, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/polyline_stroke_hit_test_core.sv -----
// polyline stroke hit test: one shared multiplier, square root and divider under a sequencer
// per sample: first of a stroke 2 products and a 33-step root; later 16 products, two
// 33-step roots and a 32-step divide, but one root off-segment and no divide if saturated
// samples after a fill hit are dropped; the rate is set by the one-bit-a-cycle root and divider
// one sample is in work at a time; a finished result waits in the output register
// reset (async, active low) clears registers to their reset values and the running minimum
// to all ones; the sample stores and the multiplier payload registers are not reset
`default_nettype none
module polyline_stroke_hit_test_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  psht_cfg_if.sink      cfg_i,
  psht_smp_if.sink      smp_i,
  psht_res_if.source    res_o
);

  psht_pkg::state_e state_q;

  logic signed [31:0] qx_q, qy_q, bx0_q, by0_q, bx1_q, by1_q;
  logic [30:0]        tol_q;
  logic               outline_q;

  psht_pkg::smp_t cur_q, prv_q;
  logic           last_q;
  logic [31:0]    min_q;
  logic           seen_q, done_q;

  // multiplier pipeline
  logic [3:0]         iss_q;
  logic               iss_run_q;
  logic               s1_v_q, s2_v_q;
  logic [3:0]         s1_op_q, s2_op_q;
  logic signed [32:0] a_q, b_q;
  logic signed [65:0] prod_q;
  logic signed [66:0] acc_q, pd2_q, seg2_q, tx_q, dt_q;
  logic               quad_q, seg_ok_q;

  // root and divider
  logic [65:0] rad_q;
  logic [34:0] rem_q;
  logic [32:0] root_q, len_q;
  logic [5:0]  cnt_q;
  logic [32:0] dr_q;
  logic [31:0] dlo_q, dq_q;

  logic        ov_q, osel_q;
  logic [31:0] odist_q;

  // ---------------------------------------------------------------- config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q <= '0; qy_q <= '0; tol_q <= '0; outline_q <= 1'b0;
      bx0_q <= 32'sd1; by0_q <= 32'sd1; bx1_q <= '0; by1_q <= '0;
    end else if (cfg_i.valid) begin
      case (psht_pkg::reg_idx_e'(cfg_i.index))
        psht_pkg::REG_QUERY_X:   qx_q <= cfg_i.data;
        psht_pkg::REG_QUERY_Y:   qy_q <= cfg_i.data;
        psht_pkg::REG_TOLERANCE: tol_q <= cfg_i.data[30:0];
        psht_pkg::REG_OUTLINE:   outline_q <= cfg_i.data[0];
        psht_pkg::REG_BOX_MIN_X: bx0_q <= cfg_i.data;
        psht_pkg::REG_BOX_MIN_Y: by0_q <= cfg_i.data;
        psht_pkg::REG_BOX_MAX_X: bx1_q <= cfg_i.data;
        psht_pkg::REG_BOX_MAX_Y: by1_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // box grown by the tolerance, inclusive
  logic signed [33:0] tol_s, qx_e, qy_e;
  logic               box_ok;
  always_comb begin
    tol_s = $signed({3'b000, tol_q});
    qx_e  = 34'(qx_q);
    qy_e  = 34'(qy_q);
    box_ok = (bx0_q <= bx1_q) && (by0_q <= by1_q)
          && (qx_e >= 34'(bx0_q) - tol_s) && (qx_e <= 34'(bx1_q) + tol_s)
          && (qy_e >= 34'(by0_q) - tol_s) && (qy_e <= 34'(by1_q) + tol_s);
  end

  // ---------------------------------------------------------------- operands
  logic signed [31:0] am, as, bm, bs;
  logic               op_sub;
  psht_pkg::op_e      last_op;

  assign last_op = seen_q ? psht_pkg::OP_C3B : psht_pkg::OP_DYY;

  always_comb begin
    am = cur_q.sx; as = qx_q; bm = cur_q.sx; bs = qx_q;
    case (psht_pkg::op_e'(iss_q))
      psht_pkg::OP_DXX:  begin am = cur_q.sx; as = qx_q; bm = cur_q.sx; bs = qx_q; end
      psht_pkg::OP_DYY:  begin am = cur_q.sy; as = qy_q; bm = cur_q.sy; bs = qy_q; end
      psht_pkg::OP_SXX:  begin am = cur_q.sx; as = prv_q.sx; bm = cur_q.sx; bs = prv_q.sx; end
      psht_pkg::OP_SYY:  begin am = cur_q.sy; as = prv_q.sy; bm = cur_q.sy; bs = prv_q.sy; end
      psht_pkg::OP_PXSX: begin am = qx_q; as = prv_q.sx; bm = cur_q.sx; bs = prv_q.sx; end
      psht_pkg::OP_PYSY: begin am = qy_q; as = prv_q.sy; bm = cur_q.sy; bs = prv_q.sy; end
      psht_pkg::OP_PXSY: begin am = qx_q; as = prv_q.sx; bm = cur_q.sy; bs = prv_q.sy; end
      psht_pkg::OP_PYSX: begin am = qy_q; as = prv_q.sy; bm = cur_q.sx; bs = prv_q.sx; end
      psht_pkg::OP_C0A:  begin am = prv_q.nx; as = '0; bm = qy_q; bs = prv_q.ry; end
      psht_pkg::OP_C0B:  begin am = prv_q.ny; as = '0; bm = qx_q; bs = prv_q.rx; end
      psht_pkg::OP_C1A:  begin am = cur_q.nx; as = '0; bm = qy_q; bs = cur_q.ly; end
      psht_pkg::OP_C1B:  begin am = cur_q.ny; as = '0; bm = qx_q; bs = cur_q.lx; end
      psht_pkg::OP_C2A:  begin am = prv_q.rx; as = cur_q.rx; bm = qy_q; bs = prv_q.ry; end
      psht_pkg::OP_C2B:  begin am = prv_q.ry; as = cur_q.ry; bm = qx_q; bs = prv_q.rx; end
      psht_pkg::OP_C3A:  begin am = cur_q.lx; as = prv_q.lx; bm = qy_q; bs = cur_q.ly; end
      psht_pkg::OP_C3B:  begin am = cur_q.ly; as = prv_q.ly; bm = qx_q; bs = cur_q.lx; end
      default: ;
    endcase
  end

  // first quad cross is negated so all four tests read as sign >= 0
  always_comb begin
    case (psht_pkg::op_e'(s2_op_q))
      psht_pkg::OP_PYSX, psht_pkg::OP_C0A, psht_pkg::OP_C1B,
      psht_pkg::OP_C2B, psht_pkg::OP_C3B: op_sub = 1'b1;
      default: op_sub = 1'b0;
    endcase
  end

  logic signed [66:0] term, sum;
  always_comb begin
    term = op_sub ? -67'(prod_q) : 67'(prod_q);
    sum  = (s2_op_q[0] ? acc_q : 67'sd0) + term;
  end

  // ---------------------------------------------------------------- root / divide steps
  logic [36:0] rem_sh, trial;
  logic        sq_ge;
  logic [32:0] root_d;
  always_comb begin
    rem_sh = {rem_q, rad_q[65:64]};
    trial  = {2'b00, root_q, 2'b01};
    sq_ge  = rem_sh >= trial;
    root_d = {root_q[31:0], sq_ge};
  end

  logic [33:0] dv_sh;
  logic        dv_ge;
  logic [31:0] dq_d;
  always_comb begin
    dv_sh = {dr_q, dlo_q[31]};
    dv_ge = dv_sh >= {1'b0, len_q};
    dq_d  = {dq_q[30:0], dv_ge};
  end

  logic [65:0] dt_mag;
  assign dt_mag = dt_q[66] ? 66'(-dt_q) : dt_q[65:0];

  logic [31:0] pdist, cand;
  assign pdist = root_d[32] ? '1 : root_d[31:0];

  logic seg_ok_d;
  assign seg_ok_d = seen_q && (seg2_q != '0) && !tx_q[66] && (tx_q <= seg2_q);

  // ---------------------------------------------------------------- finish decision
  logic fill, have_out, out_free, sel;
  always_comb begin
    fill     = seen_q && !outline_q && box_ok && quad_q;
    have_out = fill || last_q;
    out_free = !ov_q || res_o.ready;
    sel      = fill || (box_ok && (min_q <= {1'b0, tol_q}));
  end

  assign smp_i.ready = (state_q == psht_pkg::ST_IDLE);

  always_comb begin
    cand = min_q;
    case (state_q)
      psht_pkg::ST_PSQ: cand = pdist;
      psht_pkg::ST_SSQ: cand = '1;
      psht_pkg::ST_DIV: cand = dq_d;
      default: cand = min_q;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s1_op_q <= iss_q;
    a_q     <= 33'(am) - 33'(as);
    b_q     <= 33'(bm) - 33'(bs);
    s2_op_q <= s1_op_q;
    prod_q  <= a_q * b_q;
    if (s2_v_q) begin
      acc_q <= sum;
      case (psht_pkg::op_e'(s2_op_q))
        psht_pkg::OP_DYY:  pd2_q <= sum;
        psht_pkg::OP_SYY:  seg2_q <= sum;
        psht_pkg::OP_PYSY: tx_q <= sum;
        psht_pkg::OP_PYSX: dt_q <= sum;
        default: ;
      endcase
    end
    if (smp_i.valid && smp_i.ready) begin
      cur_q.sx <= smp_i.sample_x;
      cur_q.sy <= smp_i.sample_y;
      cur_q.nx <= 32'(smp_i.normal_x);
      cur_q.ny <= 32'(smp_i.normal_y);
      cur_q.rx <= smp_i.right_x;
      cur_q.ry <= smp_i.right_y;
      cur_q.lx <= smp_i.left_x;
      cur_q.ly <= smp_i.left_y;
      last_q   <= smp_i.last_sample;
    end
    if (state_q == psht_pkg::ST_FIN && (out_free || !have_out)) begin
      prv_q <= cur_q;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= psht_pkg::ST_IDLE;
      min_q     <= '1;
      seen_q    <= 1'b0;
      done_q    <= 1'b0;
      iss_q     <= '0;
      iss_run_q <= 1'b0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      quad_q    <= 1'b0;
      seg_ok_q  <= 1'b0;
      rad_q     <= '0;
      rem_q     <= '0;
      root_q    <= '0;
      len_q     <= '0;
      cnt_q     <= '0;
      dr_q      <= '0;
      dlo_q     <= '0;
      dq_q      <= '0;
      ov_q      <= 1'b0;
      osel_q    <= 1'b0;
      odist_q   <= '0;
    end else begin
      s1_v_q <= iss_run_q;
      s2_v_q <= s1_v_q;
      if (ov_q && res_o.ready) ov_q <= 1'b0;

      case (state_q)
        psht_pkg::ST_IDLE: begin
          if (smp_i.valid) begin
            if (done_q) begin
              // stroke already hit: sample only ends the stroke when last
              if (smp_i.last_sample) begin
                min_q <= '1; seen_q <= 1'b0; done_q <= 1'b0;
              end
            end else begin
              iss_q     <= '0;
              iss_run_q <= 1'b1;
              quad_q    <= 1'b1;
              state_q   <= psht_pkg::ST_MUL;
            end
          end
        end

        psht_pkg::ST_MUL: begin
          if (iss_run_q) begin
            if (iss_q == last_op) iss_run_q <= 1'b0;
            else iss_q <= iss_q + 4'd1;
          end
          if (s2_v_q && s2_op_q[3] && s2_op_q[0]) quad_q <= quad_q & !sum[66];
          if (s2_v_q && s2_op_q == last_op) begin
            rad_q   <= (s2_op_q == psht_pkg::OP_DYY) ? sum[65:0] : pd2_q[65:0];
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= '0;
            state_q <= psht_pkg::ST_PSQ;
          end
        end

        psht_pkg::ST_PSQ, psht_pkg::ST_SSQ: begin
          rad_q  <= {rad_q[63:0], 2'b00};
          rem_q  <= sq_ge ? 35'(rem_sh - trial) : rem_sh[34:0];
          root_q <= root_d;
          cnt_q  <= cnt_q + 6'd1;
          if (cnt_q == 6'd32) begin
            if (state_q == psht_pkg::ST_PSQ) begin
              if (cand < min_q) min_q <= cand;
              seg_ok_q <= seg_ok_d;
              if (seg_ok_d) begin
                rad_q   <= seg2_q[65:0];
                rem_q   <= '0;
                root_q  <= '0;
                cnt_q   <= '0;
                state_q <= psht_pkg::ST_SSQ;
              end else begin
                state_q <= psht_pkg::ST_FIN;
              end
            end else begin
              len_q <= root_d;
              if (dt_mag[65:32] >= {1'b0, root_d}) begin
                // quotient beyond 32 bits saturates, never below a running minimum
                if (cand < min_q) min_q <= cand;
                state_q <= psht_pkg::ST_FIN;
              end else begin
                dr_q    <= dt_mag[64:32];
                dlo_q   <= dt_mag[31:0];
                dq_q    <= '0;
                cnt_q   <= '0;
                state_q <= psht_pkg::ST_DIV;
              end
            end
          end
        end

        psht_pkg::ST_DIV: begin
          dr_q  <= dv_ge ? 33'(dv_sh - {1'b0, len_q}) : dv_sh[32:0];
          dlo_q <= {dlo_q[30:0], 1'b0};
          dq_q  <= dq_d;
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) begin
            if (cand < min_q) min_q <= cand;
            state_q <= psht_pkg::ST_FIN;
          end
        end

        psht_pkg::ST_FIN: begin
          if (out_free || !have_out) begin
            if (have_out) begin
              ov_q    <= 1'b1;
              osel_q  <= sel;
              odist_q <= (sel && !fill) ? min_q : '0;
            end
            seen_q <= 1'b1;
            if (fill) done_q <= 1'b1;
            if (last_q) begin
              min_q <= '1; seen_q <= 1'b0; done_q <= 1'b0;
            end
            state_q <= psht_pkg::ST_IDLE;
          end
        end

        default: state_q <= psht_pkg::ST_IDLE;
      endcase
    end
  end

  assign res_o.valid        = ov_q;
  assign res_o.selected     = osel_q;
  assign res_o.hit_distance = odist_q;

  // ---------------------------------------------------------------- checks
  a_unsel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.selected |-> res_o.hit_distance == '0)
    else $error("unselected item carries a distance");

  a_sel_in_tol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.selected |-> res_o.hit_distance <= {1'b0, tol_q})
    else $error("selected item beyond tolerance");

  a_div_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == psht_pkg::ST_DIV |-> seg_ok_q && cnt_q <= 6'd31)
    else $error("division without a valid segment");

  a_root_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == psht_pkg::ST_PSQ || state_q == psht_pkg::ST_SSQ) |-> cnt_q <= 6'd32)
    else $error("root step count overrun");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid && $stable(res_o.hit_distance))
    else $error("waiting item lost");

endmodule
`default_nettype wire
